### sv/grcc_pkg.sv
// Package for the grid ray column caster: sizes, colour codes, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
package grcc_pkg;

    localparam int MAP_SIZE      = 32;
    localparam int SCREEN_HEIGHT = 512;

    localparam int MAP_BITS   = $clog2(MAP_SIZE);
    localparam int MAP_CELLS  = MAP_SIZE * MAP_SIZE;
    localparam int ADDR_W     = 2 * MAP_BITS;
    localparam int COORD_W    = MAP_BITS + 2;
    localparam int CELL_W     = 4;
    localparam int MAX_STEPS  = 2 * MAP_SIZE + 2;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int ROW_W      = 9;
    localparam int DIST_W     = 32;
    localparam int FRAC       = 16;
    localparam int NUM_W      = 24;
    localparam int MAG_W      = 22;
    localparam int DIR_W      = 19;
    localparam int POS_W      = 21;
    localparam int DVD_W      = MAG_W + FRAC;
    localparam int DVS_W      = 32;
    localparam int DIV_CNT_W  = $clog2(DVD_W);
    localparam int LH_NUM     = SCREEN_HEIGHT * 65536;
    localparam int LH_W       = $clog2(LH_NUM) + 1;
    localparam int LH_ZERO    = SCREEN_HEIGHT * 4;
    localparam int HALF_H     = SCREEN_HEIGHT / 2;
    localparam int COLOR_W    = 24;

    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    localparam logic [CELL_W-1:0] CODE_RED   = 4'd1;
    localparam logic [CELL_W-1:0] CODE_WHITE = 4'd2;
    localparam logic [CELL_W-1:0] CODE_BLUE  = 4'd3;
    localparam logic [CELL_W-1:0] CODE_WHITE2 = 4'd4;
    localparam logic [CELL_W-1:0] CODE_FACE  = 4'd8;
    localparam logic [CELL_W-1:0] CODE_BLACK = 4'd9;

    localparam logic [COLOR_W-1:0] COL_RED    = 24'hFF0000;
    localparam logic [COLOR_W-1:0] COL_WHITE  = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COL_SKY    = 24'h0045FF;
    localparam logic [COLOR_W-1:0] COL_CYAN   = 24'h00FFFF;
    localparam logic [COLOR_W-1:0] COL_YELLOW = 24'hFFFF00;
    localparam logic [COLOR_W-1:0] COL_BLUE   = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COL_GREEN  = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COL_BLACK  = 24'h000000;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_STEP, ST_CHECK,
        ST_DIV1S, ST_DIV1W, ST_DIV2S, ST_DIV2W, ST_FIN
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic wr_cell;
        logic load;
        logic step;
        logic miss;
        logic hit;
        logic div1_start;
        logic div1_end;
        logic div2_start;
        logic div2_end;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic start_in_map;
        logic oob;
        logic cell_nz;
        logic last_step;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

### sv/grcc_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on grcc_pkg.
module grcc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [grcc_pkg::DVD_W-1:0] dividend,
    input  logic [grcc_pkg::DVS_W-1:0] divisor,
    output logic                       done,
    output logic [grcc_pkg::DVD_W-1:0] quotient
);
    import grcc_pkg::*;

    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DVS_W:0]       rem_sh, rem_sub;
    logic                 q_bit;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        q_bit    = (rem_sh >= {1'b0, dvs_reg});
        rem_next = q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### sv/grcc_dp.sv
// Datapath: map memory, DDA walk registers, distance and height arithmetic,
// output register. Depends on grcc_pkg and grcc_div.
module grcc_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  grcc_pkg::cmd_t               cmd,
    output grcc_pkg::stat_t              stat,
    input  logic [4:0]                   s_cell_x,
    input  logic [4:0]                   s_cell_y,
    input  logic [3:0]                   s_cell_value,
    input  logic [31:0]                  s_side_dist_x,
    input  logic [31:0]                  s_side_dist_y,
    input  logic [31:0]                  s_delta_dist_x,
    input  logic [31:0]                  s_delta_dist_y,
    input  logic [20:0]                  s_ray_pos_x,
    input  logic [20:0]                  s_ray_pos_y,
    input  logic signed [18:0]           s_ray_dir_x,
    input  logic signed [18:0]           s_ray_dir_y,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [8:0]                   m_draw_start,
    output logic [8:0]                   m_draw_end,
    output logic [23:0]                  m_wall_color,
    output logic                         m_hit_side,
    output logic [31:0]                  m_wall_distance,
    output logic [3:0]                   m_hit_code,
    output logic                         m_off_map
);
    import grcc_pkg::*;

    // map memory
    logic [CELL_W-1:0] map_mem [MAP_CELLS];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              mem_we, wr_in_map;

    // walk state
    logic [DIST_W-1:0]  sdx_reg, sdy_reg, ddx_reg, ddy_reg;
    logic [COORD_W-1:0] mx_reg, my_reg, mx_step, my_step;
    logic [POS_W-1:0]   posx_reg, posy_reg;
    logic signed [DIR_W-1:0] dirx_reg, diry_reg;
    logic [STEP_W-1:0]  step_cnt_reg;
    logic               side_reg, hit_reg, flag_reg;
    logic [CELL_W-1:0]  code_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [LH_W-1:0]    lh_reg;
    logic               x_first;
    logic [DIST_W:0]    sum_x, sum_y;

    // distance
    logic [MAP_BITS-1:0]     cell_sel;
    logic [POS_W-1:0]        pos_sel;
    logic signed [DIR_W-1:0] dir_sel;
    logic                    neg_sel;
    logic signed [NUM_W-1:0] num_s, num_abs;
    logic [DIR_W-1:0]        dir_mag;
    logic                    num_mismatch;
    logic [DVD_W-1:0]        dvd, quo;
    logic [DVS_W-1:0]        dvs;
    logic                    div_done;

    // result
    logic [LH_W-2:0]    half;
    logic [ROW_W-1:0]   ds, de;
    logic [COLOR_W-1:0] color;
    logic               m_valid_reg;

    function automatic logic [COLOR_W-1:0] pick_color(
        input logic [CELL_W-1:0] code, input logic side, input logic xneg,
        input logic yneg);
        logic [COLOR_W-1:0] c;
        begin
            unique case (code)
                CODE_RED:    c = COL_RED;
                CODE_WHITE:  c = COL_WHITE;
                CODE_BLUE:   c = COL_SKY;
                CODE_WHITE2: c = COL_WHITE;
                CODE_BLACK:  c = COL_BLACK;
                default:     c = COL_CYAN;
            endcase
            if (side) c = c >> 1;
            if (code == CODE_FACE) begin
                if (!side) c = xneg ? COL_RED : COL_YELLOW;
                else       c = yneg ? COL_BLUE : COL_GREEN;
            end
            return c;
        end
    endfunction

    // memory access
    assign wr_in_map = ({1'b0, s_cell_x} < 6'(MAP_SIZE)) && ({1'b0, s_cell_y} < 6'(MAP_SIZE));
    assign mem_we    = cmd.clear_wr || (cmd.wr_cell && wr_in_map);
    assign wr_addr   = cmd.clear_wr ? clr_cnt_reg
                                    : {s_cell_x[MAP_BITS-1:0], s_cell_y[MAP_BITS-1:0]};
    assign wr_data   = cmd.clear_wr ? '0 : s_cell_value;

    always_ff @(posedge aclk) begin
        if (mem_we) map_mem[wr_addr] <= wr_data;
        rd_data_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_cnt_reg <= '0;
        else if (cmd.clear_wr) clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // one DDA step
    always_comb begin
        x_first = sdx_reg < sdy_reg;
        sum_x   = {1'b0, sdx_reg} + {1'b0, ddx_reg};
        sum_y   = {1'b0, sdy_reg} + {1'b0, ddy_reg};
        mx_step = dirx_reg[DIR_W-1] ? mx_reg - 1'b1 : mx_reg + 1'b1;
        my_step = diry_reg[DIR_W-1] ? my_reg - 1'b1 : my_reg + 1'b1;
        rd_addr = x_first ? {mx_step[MAP_BITS-1:0], my_reg[MAP_BITS-1:0]}
                          : {mx_reg[MAP_BITS-1:0], my_step[MAP_BITS-1:0]};
    end

    // distance numerator and divisor
    always_comb begin
        cell_sel = side_reg ? my_reg[MAP_BITS-1:0] : mx_reg[MAP_BITS-1:0];
        pos_sel  = side_reg ? posy_reg : posx_reg;
        dir_sel  = side_reg ? diry_reg : dirx_reg;
        neg_sel  = dir_sel[DIR_W-1];
        num_s    = $signed({{(NUM_W-MAP_BITS-FRAC){1'b0}}, cell_sel, {FRAC{1'b0}}})
                 - $signed({{(NUM_W-POS_W){1'b0}}, pos_sel})
                 + (neg_sel ? NUM_W'(65536) : NUM_W'(0));
        num_abs  = num_s[NUM_W-1] ? -num_s : num_s;
        dir_mag  = neg_sel ? DIR_W'(-dir_sel) : DIR_W'(dir_sel);
        num_mismatch = (num_s != '0) && (num_s[NUM_W-1] != neg_sel);
        if (cmd.div2_start) begin
            dvd = DVD_W'(LH_NUM);
            dvs = dist_reg;
        end else begin
            dvd = {num_abs[MAG_W-1:0], {FRAC{1'b0}}};
            dvs = DVS_W'(dir_mag);
        end
    end

    grcc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div1_start || cmd.div2_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sdx_reg  <= s_side_dist_x;
            sdy_reg  <= s_side_dist_y;
            ddx_reg  <= s_delta_dist_x;
            ddy_reg  <= s_delta_dist_y;
            mx_reg   <= COORD_W'(s_cell_x);
            my_reg   <= COORD_W'(s_cell_y);
            posx_reg <= s_ray_pos_x;
            posy_reg <= s_ray_pos_y;
            dirx_reg <= s_ray_dir_x;
            diry_reg <= s_ray_dir_y;
            step_cnt_reg <= '0;
            side_reg <= 1'b0;
            hit_reg  <= 1'b0;
            flag_reg <= 1'b0;
            code_reg <= '0;
            dist_reg <= DIST_SAT;
        end
        if (cmd.step) begin
            step_cnt_reg <= step_cnt_reg + 1'b1;
            if (x_first) begin
                sdx_reg  <= sum_x[DIST_W] ? DIST_SAT : sum_x[DIST_W-1:0];
                mx_reg   <= mx_step;
                side_reg <= 1'b0;
            end else begin
                sdy_reg  <= sum_y[DIST_W] ? DIST_SAT : sum_y[DIST_W-1:0];
                my_reg   <= my_step;
                side_reg <= 1'b1;
            end
        end
        if (cmd.miss) flag_reg <= 1'b1;
        if (cmd.hit) begin
            hit_reg  <= 1'b1;
            code_reg <= rd_data_reg;
        end
        if (cmd.div1_end) begin
            priority if (dir_sel == '0) begin
                dist_reg <= DIST_SAT;
                flag_reg <= 1'b1;
            end else if (num_mismatch) begin
                dist_reg <= '0;
            end else if (quo[DVD_W-1:DIST_W] != '0) begin
                dist_reg <= DIST_SAT;
                flag_reg <= 1'b1;
            end else begin
                dist_reg <= quo[DIST_W-1:0];
            end
        end
        if (cmd.div2_end) begin
            if (dist_reg == '0) begin
                lh_reg   <= LH_W'(LH_ZERO);
                flag_reg <= 1'b1;
            end else begin
                lh_reg <= quo[LH_W-1:0];
            end
        end
    end

    // rows and colour
    always_comb begin
        half = lh_reg[LH_W-1:1];
        if (half >= (LH_W-1)'(HALF_H)) begin
            ds = '0;
            de = ROW_W'(SCREEN_HEIGHT - 1);
        end else begin
            ds = ROW_W'(HALF_H) - ROW_W'(half);
            de = ROW_W'(half) + ROW_W'(HALF_H);
        end
        color = hit_reg ? pick_color(code_reg, side_reg, dirx_reg[DIR_W-1], diry_reg[DIR_W-1])
                        : COL_BLACK;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (cmd.out_load) m_valid_reg <= 1'b1;
        else if (m_ready) m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_draw_start    <= ds;
            m_draw_end      <= de;
            m_wall_color    <= color;
            m_hit_side      <= side_reg;
            m_wall_distance <= dist_reg;
            m_hit_code      <= code_reg;
            m_off_map       <= flag_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        stat.clear_last   = (clr_cnt_reg == ADDR_W'(MAP_CELLS - 1));
        stat.start_in_map = (mx_reg < COORD_W'(MAP_SIZE)) && (my_reg < COORD_W'(MAP_SIZE));
        stat.oob          = mx_reg[COORD_W-1] || my_reg[COORD_W-1]
                         || (mx_reg >= COORD_W'(MAP_SIZE)) || (my_reg >= COORD_W'(MAP_SIZE));
        stat.cell_nz      = (rd_data_reg != '0);
        stat.last_step    = (step_cnt_reg == STEP_W'(MAX_STEPS));
        stat.div_done     = div_done;
        stat.out_free     = !m_valid_reg || m_ready;
    end
endmodule

### sv/grcc_ctrl.sv
// Controller state machine: clearing pass, command dispatch, walk sequencing,
// division sequencing. Depends on grcc_pkg.
module grcc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_command,
    output logic             s_ready,
    input  grcc_pkg::stat_t  stat,
    output grcc_pkg::cmd_t   cmd
);
    import grcc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid && s_command == CMD_CAST) state_next = ST_START;
            ST_START: state_next = stat.start_in_map ? ST_STEP : ST_DIV2S;
            ST_STEP:  state_next = ST_CHECK;
            ST_CHECK: begin
                priority if (stat.oob)       state_next = ST_DIV2S;
                else if (stat.cell_nz)       state_next = ST_DIV1S;
                else if (stat.last_step)     state_next = ST_DIV2S;
                else                         state_next = ST_STEP;
            end
            ST_DIV1S: state_next = ST_DIV1W;
            ST_DIV1W: if (stat.div_done) state_next = ST_DIV2S;
            ST_DIV2S: state_next = ST_DIV2W;
            ST_DIV2W: if (stat.div_done) state_next = ST_FIN;
            ST_FIN:   if (stat.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_wr = 1'b1;
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.wr_cell = s_valid && (s_command == CMD_WRITE);
                cmd.load    = s_valid && (s_command == CMD_CAST);
            end
            ST_START: cmd.miss = !stat.start_in_map;
            ST_STEP:  cmd.step = 1'b1;
            ST_CHECK: begin
                cmd.miss = stat.oob || (!stat.cell_nz && stat.last_step);
                cmd.hit  = !stat.oob && stat.cell_nz;
            end
            ST_DIV1S: cmd.div1_start = 1'b1;
            ST_DIV1W: cmd.div1_end   = stat.div_done;
            ST_DIV2S: cmd.div2_start = 1'b1;
            ST_DIV2W: cmd.div2_end   = stat.div_done;
            ST_FIN:   cmd.out_load   = stat.out_free;
            default:  cmd = '0;
        endcase
    end
endmodule

### sv/grid_ray_column_caster_top.sv
// Top level of the grid ray column caster: joins controller and datapath.
// Depends on grcc_pkg, grcc_ctrl, grcc_dp (and grcc_div below it).
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | command, cell, distances, pos, dir
//   m_      | out       | m_valid / m_ready  | rows, colour, side, distance, code, flag
//
// A write transaction gives no result. A cast walks the map, up to 66 steps
// with one map read per step, then runs the two divisions in the shared
// one-bit-per-cycle divider (a walk that misses skips the first) and loads
// the output register. After reset a clearing pass zeroes all 1024 map cells;
// s_ready stays low during it. A finished result waits in the output register;
// the next transaction is taken meanwhile, and a cast holds before its result
// load until the register is free.
module grid_ray_column_caster_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [4:0]         s_cell_x,
    input  logic [4:0]         s_cell_y,
    input  logic [3:0]         s_cell_value,
    input  logic [31:0]        s_side_dist_x,
    input  logic [31:0]        s_side_dist_y,
    input  logic [31:0]        s_delta_dist_x,
    input  logic [31:0]        s_delta_dist_y,
    input  logic [20:0]        s_ray_pos_x,
    input  logic [20:0]        s_ray_pos_y,
    input  logic signed [18:0] s_ray_dir_x,
    input  logic signed [18:0] s_ray_dir_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [8:0]         m_draw_start,
    output logic [8:0]         m_draw_end,
    output logic [23:0]        m_wall_color,
    output logic               m_hit_side,
    output logic [31:0]        m_wall_distance,
    output logic [3:0]         m_hit_code,
    output logic               m_off_map
);
    import grcc_pkg::*;

    // command and status between the two halves
    cmd_t  cmd;
    stat_t stat;

    // sequence the clearing pass, the walk and the divisions
    grcc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hold the map, the walk registers and the output register
    grcc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_cell_x        (s_cell_x),
        .s_cell_y        (s_cell_y),
        .s_cell_value    (s_cell_value),
        .s_side_dist_x   (s_side_dist_x),
        .s_side_dist_y   (s_side_dist_y),
        .s_delta_dist_x  (s_delta_dist_x),
        .s_delta_dist_y  (s_delta_dist_y),
        .s_ray_pos_x     (s_ray_pos_x),
        .s_ray_pos_y     (s_ray_pos_y),
        .s_ray_dir_x     (s_ray_dir_x),
        .s_ray_dir_y     (s_ray_dir_y),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_draw_start    (m_draw_start),
        .m_draw_end      (m_draw_end),
        .m_wall_color    (m_wall_color),
        .m_hit_side      (m_hit_side),
        .m_wall_distance (m_wall_distance),
        .m_hit_code      (m_hit_code),
        .m_off_map       (m_off_map)
    );
endmodule
